[hw/rtl/mlft_pkg.sv]
package mlft_pkg;

	localparam int PORT_COUNT = 4;
	localparam int MAC_W      = 48;
	localparam int PORT_W     = 2;
	localparam int MASK_W     = 4;

	// Ports that exist, limited to the width of the egress mask.
	localparam logic [MASK_W-1:0] ALL_PORTS = (PORT_COUNT >= MASK_W) ? {MASK_W{1'b1}}
		: MASK_W'((1 << PORT_COUNT) - 1);

	localparam int FRONT_DEPTH  = 2;
	localparam int RESULT_DEPTH = 2;

	typedef struct packed {
		logic [PORT_W-1:0] in_port;
		logic [MAC_W-1:0]  src_mac;
		logic [MAC_W-1:0]  dst_mac;
	} in_item_t;

	typedef struct packed {
		logic [MASK_W-1:0] egress_mask;
		logic              dest_known;
		logic              learn_dropped;
	} out_item_t;

	// Header after classification, as the lookup engine consumes it.
	typedef struct packed {
		logic [PORT_W-1:0] in_port;
		logic [MAC_W-1:0]  src_mac;
		logic [MAC_W-1:0]  dst_mac;
		logic              same_mac;
		logic [MASK_W-1:0] flood_mask;
	} work_item_t;

	typedef struct packed {
		logic [MAC_W-1:0]  mac;
		logic [PORT_W-1:0] port;
	} entry_t;

endpackage

[hw/rtl/mac_learning_forward_table_top.sv]
// An accepted header beat waits in the work queue, where two headers queue ahead of the lookup
// engine; the engine takes one only when idle and the result queue has room. It scans the N learned
// entries (0 to TABLE_ENTRIES) through the single read port of the entry RAM, one entry per cycle,
// waits out the last read, then learns and pushes the result beat; an empty table skips both steps.
// Reset: arst_n clears the fill count, the queues and the engine; the table is then empty and
// the RAM is left as it is, with no clearing pass.
module mac_learning_forward_table_top import mlft_pkg::*; #(
	parameter int TABLE_ENTRIES = 64
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  in_item_t  item,
	output logic      full,
	output out_item_t result,
	output logic      empty,
	input  logic      pop
);

	work_item_t work;
	logic       work_valid;
	logic       work_pop;

	mlft_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.item      (item),
		.full      (full),
		.work      (work),
		.work_valid(work_valid),
		.work_pop  (work_pop)
	);

	mlft_back #(
		.TABLE_ENTRIES(TABLE_ENTRIES)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.work      (work),
		.work_valid(work_valid),
		.work_pop  (work_pop),
		.result    (result),
		.empty     (empty),
		.pop       (pop)
	);

endmodule

[hw/rtl/mlft_ram.sv]
module mlft_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

[hw/rtl/mlft_fifo.sv]
module mlft_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CW-1:0]    fill_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (fill_q == CW'(DEPTH));
	assign empty   = (fill_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			unique case ({do_push, do_pop})
				2'b10:   fill_q <= fill_q + CW'(1);
				2'b01:   fill_q <= fill_q - CW'(1);
				default: fill_q <= fill_q;
			endcase
		end
	end

endmodule

[hw/rtl/mlft_front.sv]
module mlft_front import mlft_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  in_item_t   item,
	output logic       full,
	output work_item_t work,
	output logic       work_valid,
	input  logic       work_pop
);

	work_item_t classified;
	logic       work_empty;

	// The flood mask and the source-equals-destination flag only depend on the header.
	always_comb begin
		classified.in_port    = item.in_port;
		classified.src_mac    = item.src_mac;
		classified.dst_mac    = item.dst_mac;
		classified.same_mac   = (item.src_mac == item.dst_mac);
		classified.flood_mask = ALL_PORTS & ~(MASK_W'(1) << item.in_port);
	end

	assign work_valid = !work_empty;

	mlft_fifo #(
		.WIDTH($bits(work_item_t)),
		.DEPTH(FRONT_DEPTH)
	) u_work_fifo (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.wdata (classified),
		.full  (full),
		.pop   (work_pop),
		.rdata (work),
		.empty (work_empty)
	);

endmodule

[hw/rtl/mlft_back.sv]
module mlft_back import mlft_pkg::*; #(
	parameter int TABLE_ENTRIES = 64
) (
	input  logic       clk,
	input  logic       arst_n,
	input  work_item_t work,
	input  logic       work_valid,
	output logic       work_pop,
	output out_item_t  result,
	output logic       empty,
	input  logic       pop
);

	localparam int AW = $clog2(TABLE_ENTRIES);
	localparam int CW = $clog2(TABLE_ENTRIES + 1);

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_DRAIN,
		S_FINISH
	} state_t;

	state_t            state_q;
	work_item_t        work_q;
	logic [AW-1:0]     idx_q;
	logic [CW-1:0]     count_q;
	logic              cmp_vld_s1;
	logic [AW-1:0]     cmp_idx_s1;
	logic              src_hit_q;
	logic [AW-1:0]     src_idx_q;
	logic              dst_hit_q;
	logic [PORT_W-1:0] dst_port_q;

	entry_t            rd_entry;
	entry_t            wr_entry;
	logic              ram_we;
	logic [AW-1:0]     ram_waddr;
	logic              src_match;
	logic              dst_match;
	logic              table_full;
	logic              last_issue;
	logic              res_push;
	logic              res_full;
	out_item_t         res_data;
	logic              dropped;
	logic              known;
	logic [PORT_W-1:0] hit_port;

	// Slots fill from the bottom and are never freed, so slot i is valid when i < count_q.
	assign table_full = (count_q == CW'(TABLE_ENTRIES));
	assign last_issue = ((CW'(idx_q) + CW'(1)) == count_q);
	assign src_match  = cmp_vld_s1 && (rd_entry.mac == work_q.src_mac);
	assign dst_match  = cmp_vld_s1 && (rd_entry.mac == work_q.dst_mac);
	assign work_pop   = (state_q == S_IDLE) && work_valid && !res_full;

	always_comb begin
		dropped  = !src_hit_q && table_full;
		// A destination equal to the source sees the entry just learned.
		known    = work_q.same_mac ? !dropped : dst_hit_q;
		hit_port = work_q.same_mac ? work_q.in_port : dst_port_q;
		res_data.egress_mask   = known ? ((MASK_W'(1) << hit_port) & ALL_PORTS)
			: work_q.flood_mask;
		res_data.dest_known    = known;
		res_data.learn_dropped = dropped;
		res_push = (state_q == S_FINISH);

		ram_we        = (state_q == S_FINISH) && (src_hit_q || !table_full);
		ram_waddr     = src_hit_q ? src_idx_q : count_q[AW-1:0];
		wr_entry.mac  = work_q.src_mac;
		wr_entry.port = work_q.in_port;
	end

	always_ff @(posedge clk) begin
		if (work_pop) begin
			work_q <= work;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			count_q    <= '0;
			idx_q      <= '0;
			cmp_vld_s1 <= 1'b0;
			cmp_idx_s1 <= '0;
			src_hit_q  <= 1'b0;
			src_idx_q  <= '0;
			dst_hit_q  <= 1'b0;
			dst_port_q <= '0;
		end else begin
			cmp_vld_s1 <= (state_q == S_SCAN);
			cmp_idx_s1 <= idx_q;
			if (src_match) begin
				src_hit_q <= 1'b1;
				src_idx_q <= cmp_idx_s1;
			end
			if (dst_match) begin
				dst_hit_q  <= 1'b1;
				dst_port_q <= rd_entry.port;
			end
			unique case (state_q)
				S_IDLE: begin
					if (work_pop) begin
						idx_q     <= '0;
						src_hit_q <= 1'b0;
						dst_hit_q <= 1'b0;
						state_q   <= (count_q == '0) ? S_FINISH : S_SCAN;
					end
				end
				S_SCAN: begin
					idx_q <= idx_q + AW'(1);
					if (last_issue) begin
						state_q <= S_DRAIN;
					end
				end
				S_DRAIN: begin
					state_q <= S_FINISH;
				end
				S_FINISH: begin
					if (!src_hit_q && !table_full) begin
						count_q <= count_q + CW'(1);
					end
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	mlft_ram #(
		.WIDTH($bits(entry_t)),
		.DEPTH(TABLE_ENTRIES)
	) u_entry_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(wr_entry),
		.raddr(idx_q),
		.rdata(rd_entry)
	);

	mlft_fifo #(
		.WIDTH($bits(out_item_t)),
		.DEPTH(RESULT_DEPTH)
	) u_result_fifo (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (res_push),
		.wdata (res_data),
		.full  (res_full),
		.pop   (pop),
		.rdata (result),
		.empty (empty)
	);

	assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(TABLE_ENTRIES))
		else $error("fill count beyond table size");

	assert property (@(posedge clk) disable iff (!arst_n)
		res_push |-> !res_full)
		else $error("result beat pushed into a full result queue");

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_FINISH) |=> $stable(count_q))
		else $error("fill count moved outside the learn step");

	assert property (@(posedge clk) disable iff (!arst_n)
		(res_push && res_data.learn_dropped) |-> (table_full && !ram_we))
		else $error("learn dropped while a slot was free");

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN) |-> (CW'(idx_q) < count_q))
		else $error("scan read beyond the filled slots");

endmodule
